/* design/smig_pkg.sv */
// ----------------------------------------------------------------------------
// smig_pkg: shared types and constants of the stepper move interval generator
// Field widths, status codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package smig_pkg;

	localparam int MAX_STEPS    = 64;
	localparam int AXES         = 4;

	localparam int AXIS_IN_W    = 2;
	localparam int TIME_W       = 32;
	localparam int POS_W        = 32;
	localparam int INTERVAL_W   = 17;
	localparam int PRESCALE_W   = 16;
	localparam int STATUS_W     = 2;

	// Normalized duration width; values at or above 2**NORM_W get halved
	localparam int NORM_W       = 16;
	localparam int AXIS_W       = $clog2(AXES);
	// Holds a step count up to MAX_STEPS inclusive
	localparam int STEP_W       = $clog2(MAX_STEPS + 1);
	// One mask bit per ruler level of a step index
	localparam int MASK_W       = STEP_W;
	localparam int KW           = $clog2(MASK_W);

	typedef enum logic [STATUS_W-1:0] {
		ST_STEP    = 2'd0,
		ST_NOMOVE  = 2'd1,
		ST_TOOLONG = 2'd2
	} status_t;

	typedef struct packed {
		logic    load;
		logic    shift;
		logic    latch_steps;
		logic    div_step;
		logic    mask_init;
		logic    mask_step;
		logic    cnt_clr;
		logic    emit_step;
		logic    emit_single;
		status_t single_code;
	} dp_cmd_t;

	typedef struct packed {
		logic x_big;
		logic diff_zero;
		logic too_long;
		logic div_last;
		logic mask_done;
		logic last_step;
	} dp_sts_t;

endpackage

`default_nettype wire

/* design/smig_if.sv */
// ----------------------------------------------------------------------------
// smig_if: request and result channel interfaces
// Valid/ready channels carrying the move request and the step result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface smig_cmd_if;
	logic                                   valid;
	logic                                   ready;
	logic        [smig_pkg::AXIS_IN_W-1:0] axis;
	logic        [smig_pkg::TIME_W-1:0]    move_time;
	logic signed [smig_pkg::POS_W-1:0]     target_position;

	modport source (output valid, axis, move_time, target_position, input ready);
	modport sink   (input valid, axis, move_time, target_position, output ready);
endinterface

interface smig_res_if;
	logic                               valid;
	logic                               ready;
	logic [smig_pkg::INTERVAL_W-1:0]   interval;
	logic [smig_pkg::PRESCALE_W-1:0]   prescale;
	logic                               direction;
	logic [smig_pkg::STATUS_W-1:0]     status;
	logic                               last;

	modport source (output valid, interval, prescale, direction, status, last, input ready);
	modport sink   (input valid, interval, prescale, direction, status, last, output ready);
endinterface

`default_nettype wire

/* design/stepper_move_interval_generator.sv */
// ----------------------------------------------------------------------------
// stepper_move_interval_generator: per-step timer reloads for a stepper move
// Takes a move request (axis, duration, target), normalizes the duration to
// 16 bits with a power-of-two prescaler and emits one reload per step.
// ----------------------------------------------------------------------------
//
//   port  role    payload                                   carries
//   ----  ------  ----------------------------------------  ------------------
//   cmd   sink    axis, move_time, target_position          one move request
//   res   source  interval, prescale, direction, status,     one result each
//                 last                                        step (or one flag)
//
// Sequence: a request is taken in idle, halved until it fits in 16 bits and then
//   checked; a no-move or too-long request then yields its single result. A real
//   move goes on to the serial divider, a setup state and the mask unit, then
//   emits one result per cycle while a low res.ready does not hold the emit phase.
//   The divider yields one quotient bit per cycle.
// Reset: arst_n clears the state machine, the result valid flag and all four
//   axis positions to zero.
// Stalls: the result register frees as soon as res.ready takes it; a low
//   res.ready holds the emit phase, and the next request is taken while the
//   final result of the previous one still waits.
`default_nettype none

module stepper_move_interval_generator (
	input  logic       clk,
	input  logic       arst_n,
	smig_cmd_if.sink   cmd,
	smig_res_if.source res
);

	smig_pkg::dp_cmd_t ctl;
	smig_pkg::dp_sts_t sts;

	// Sequencer: decides each cycle which datapath operation runs and
	// tracks whether the result register holds an untaken result.
	smig_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	// Datapath: positions are updated on request accept; the divider, mask
	// unit and result register work on the captured request.
	smig_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.axis            (cmd.axis),
		.move_time       (cmd.move_time),
		.target_position (cmd.target_position),
		.interval        (res.interval),
		.prescale        (res.prescale),
		.direction       (res.direction),
		.status          (res.status),
		.last            (res.last)
	);

endmodule

`default_nettype wire

/* design/smig_dp.sv */
// ----------------------------------------------------------------------------
// smig_dp: datapath of the stepper move interval generator
// Axis positions, duration normalizer, serial divider, spread-mask unit and
// the result register, all stepped by the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module smig_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  smig_pkg::dp_cmd_t                     ctl,
	output smig_pkg::dp_sts_t                     sts,
	input  logic        [smig_pkg::AXIS_IN_W-1:0] axis,
	input  logic        [smig_pkg::TIME_W-1:0]    move_time,
	input  logic signed [smig_pkg::POS_W-1:0]     target_position,
	output logic        [smig_pkg::INTERVAL_W-1:0] interval,
	output logic        [smig_pkg::PRESCALE_W-1:0] prescale,
	output logic                                  direction,
	output logic        [smig_pkg::STATUS_W-1:0]  status,
	output logic                                  last
);

	logic signed [smig_pkg::POS_W-1:0]      pos_q [smig_pkg::AXES];
	logic        [smig_pkg::TIME_W-1:0]     x_q;
	logic        [smig_pkg::PRESCALE_W-1:0] pre_q;
	logic signed [smig_pkg::POS_W:0]        diff_q;
	logic        [smig_pkg::STEP_W-1:0]     steps_q;
	logic        [smig_pkg::STEP_W-1:0]     cnt_q;
	logic        [smig_pkg::STEP_W-1:0]     rem_q;
	logic        [smig_pkg::STEP_W-1:0]     b_q;
	logic        [smig_pkg::STEP_W-1:0]     a_q;
	logic        [smig_pkg::MASK_W-1:0]     mask_q;

	logic [smig_pkg::INTERVAL_W-1:0] interval_q;
	logic [smig_pkg::PRESCALE_W-1:0] prescale_q;
	logic                            direction_q;
	logic [smig_pkg::STATUS_W-1:0]   status_q;
	logic                            last_q;

	logic [smig_pkg::AXIS_W-1:0]     ax;
	logic [smig_pkg::POS_W:0]        mag;
	logic [smig_pkg::STEP_W:0]       trial;
	logic                            ge;
	logic [smig_pkg::STEP_W-1:0]     rem_next;
	logic [smig_pkg::KW-1:0]         k;
	logic [smig_pkg::KW:0]           k1;
	logic [smig_pkg::STEP_W-1:0]     y;
	logic [smig_pkg::STEP_W:0]       y_rnd;
	logic [smig_pkg::STEP_W-1:0]     sub;
	logic [smig_pkg::STEP_W-1:0]     idx1;
	logic [smig_pkg::STEP_W-1:0]     ruler;
	logic                            hit;
	logic [smig_pkg::INTERVAL_W-1:0] iv;

	assign ax = smig_pkg::AXIS_W'(axis % smig_pkg::AXES);

	// Distance magnitude, 33 bits so the full signed span never wraps
	assign mag = diff_q[smig_pkg::POS_W] ? (smig_pkg::POS_W+1)'(0) - unsigned'(diff_q)
	                                     : unsigned'(diff_q);

	// Restoring divider: one quotient bit per cycle, dividend shifts out of x_q
	assign trial    = {rem_q, x_q[smig_pkg::NORM_W-1]};
	assign ge       = trial >= {1'b0, steps_q};
	assign rem_next = ge ? smig_pkg::STEP_W'(trial - {1'b0, steps_q})
	                     : smig_pkg::STEP_W'(trial);

	// Spread mask: sub = ceil((steps - (2**k - 1)) / 2**(k+1))
	assign k     = cnt_q[smig_pkg::KW-1:0];
	assign k1    = {1'b0, k} + (smig_pkg::KW+1)'(1);
	assign y     = steps_q - ((smig_pkg::STEP_W'(1) << k) - smig_pkg::STEP_W'(1));
	assign y_rnd = {1'b0, y} + (((smig_pkg::STEP_W+1)'(1) << k1)
	               - (smig_pkg::STEP_W+1)'(1));
	assign sub   = smig_pkg::STEP_W'(y_rnd >> k1);

	// Ruler level of the step index selects the mask bit
	assign idx1  = cnt_q + smig_pkg::STEP_W'(1);
	assign ruler = ~cnt_q & idx1;
	assign hit   = |(ruler & mask_q);
	assign iv    = {1'b0, x_q[smig_pkg::NORM_W-1:0]} + smig_pkg::INTERVAL_W'(hit);

	assign sts.x_big     = |x_q[smig_pkg::TIME_W-1:smig_pkg::NORM_W];
	assign sts.diff_zero = diff_q == '0;
	assign sts.too_long  = mag > (smig_pkg::POS_W+1)'(smig_pkg::MAX_STEPS);
	assign sts.div_last  = cnt_q == smig_pkg::STEP_W'(smig_pkg::NORM_W - 1);
	assign sts.mask_done = (b_q == '0) || (a_q == '0);
	assign sts.last_step = idx1 == steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < smig_pkg::AXES; i++) begin
				pos_q[i] <= '0;
			end
			cnt_q <= '0;
		end else begin
			if (ctl.load) begin
				pos_q[ax] <= target_position;
			end
			if (ctl.cnt_clr || ctl.mask_init) begin
				cnt_q <= '0;
			end else if (ctl.div_step || ctl.mask_step || ctl.emit_step) begin
				cnt_q <= cnt_q + smig_pkg::STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q    <= move_time;
			pre_q  <= '0;
			diff_q <= (smig_pkg::POS_W+1)'(target_position) - (smig_pkg::POS_W+1)'(pos_q[ax]);
		end else if (ctl.shift) begin
			x_q   <= x_q >> 1;
			pre_q <= {pre_q[smig_pkg::PRESCALE_W-2:0], 1'b1};
		end else if (ctl.div_step) begin
			x_q <= {x_q[smig_pkg::TIME_W-1:smig_pkg::NORM_W],
			        x_q[smig_pkg::NORM_W-2:0], ge};
		end
		if (ctl.latch_steps) begin
			steps_q <= mag[smig_pkg::STEP_W-1:0];
			rem_q   <= '0;
		end else if (ctl.div_step) begin
			rem_q <= rem_next;
		end
		if (ctl.mask_init) begin
			b_q    <= rem_q + smig_pkg::STEP_W'(1);
			a_q    <= steps_q;
			mask_q <= '0;
		end else if (ctl.mask_step) begin
			if (b_q > sub) begin
				b_q       <= b_q - sub;
				mask_q[k] <= 1'b1;
			end
			a_q <= a_q >> 1;
		end
		if (ctl.emit_step) begin
			interval_q  <= iv;
			prescale_q  <= pre_q;
			direction_q <= diff_q[smig_pkg::POS_W];
			status_q    <= smig_pkg::ST_STEP;
			last_q      <= sts.last_step;
		end else if (ctl.emit_single) begin
			interval_q  <= '0;
			prescale_q  <= pre_q;
			direction_q <= diff_q[smig_pkg::POS_W];
			status_q    <= ctl.single_code;
			last_q      <= 1'b1;
		end
	end

	assign interval  = interval_q;
	assign prescale  = prescale_q;
	assign direction = direction_q;
	assign status    = status_q;
	assign last      = last_q;

	a_steps_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.latch_steps |=> (steps_q != '0
		&& (smig_pkg::STEP_W+1)'(steps_q) <= (smig_pkg::STEP_W+1)'(smig_pkg::MAX_STEPS)))
		else $error("step count latched out of range");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mask_init |-> rem_q < steps_q)
		else $error("division remainder not below step count");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_step |-> cnt_q < steps_q)
		else $error("step index past step count");

endmodule

`default_nettype wire

/* design/smig_ctrl.sv */
// ----------------------------------------------------------------------------
// smig_ctrl: controller of the stepper move interval generator
// Sequences normalize, check, divide, mask and emit phases and owns the
// result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module smig_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	output logic              res_valid,
	input  logic              res_ready,
	output smig_pkg::dp_cmd_t ctl,
	input  smig_pkg::dp_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_NORM,
		S_CHECK,
		S_DIV,
		S_MINIT,
		S_MASK,
		S_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   slot_free;

	assign slot_free = !res_valid_q || res_ready;
	assign cmd_ready = state_q == S_IDLE;
	assign res_valid = res_valid_q;

	always_comb begin
		state_d         = state_q;
		ctl             = '0;
		ctl.single_code = smig_pkg::ST_STEP;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = S_NORM;
				end
			end
			S_NORM: begin
				if (sts.x_big) begin
					ctl.shift = 1'b1;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.diff_zero || sts.too_long) begin
					if (slot_free) begin
						ctl.emit_single = 1'b1;
						ctl.single_code = sts.diff_zero ? smig_pkg::ST_NOMOVE
						                                : smig_pkg::ST_TOOLONG;
						state_d         = S_IDLE;
					end
				end else begin
					ctl.latch_steps = 1'b1;
					ctl.cnt_clr     = 1'b1;
					state_d         = S_DIV;
				end
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_MINIT;
				end
			end
			S_MINIT: begin
				ctl.mask_init = 1'b1;
				state_d       = S_MASK;
			end
			S_MASK: begin
				if (sts.mask_done) begin
					ctl.cnt_clr = 1'b1;
					state_d     = S_EMIT;
				end else begin
					ctl.mask_step = 1'b1;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					ctl.emit_step = 1'b1;
					if (sts.last_step) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.emit_step || ctl.emit_single) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.emit_step && ctl.emit_single))
		else $error("two result loads in one cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit_step || ctl.emit_single) |-> (!res_valid_q || res_ready))
		else $error("result register overwritten before taken");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit_step && sts.last_step) |=> cmd_ready)
		else $error("no return to idle after last step");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stepper_move_interval_generator
// Drives move requests over the valid/ready request channel and predicts every
// step reload, no-move flag and too-long flag from a model of the block held
// here. Checks each result field by field, in order, under random sender
// bursts, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------

module testbench;

	localparam int DIRECTED_MOVES = 20;
	localparam int RANDOM_MOVES   = 110;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 200;
	localparam int CYCLE_LIMIT    = 400000;

	// One expected result, laid out as the result channel carries it
	typedef struct packed {
		logic [smig_pkg::INTERVAL_W-1:0] interval;
		logic [smig_pkg::PRESCALE_W-1:0] prescale;
		logic                            direction;
		smig_pkg::status_t               status;
		logic                            last;
	} reload_t;

	// One row of the directed table; fixed rows carry their single result
	typedef struct packed {
		logic [smig_pkg::AXIS_IN_W-1:0]  ax;
		logic [smig_pkg::TIME_W-1:0]     ticks;
		logic [smig_pkg::POS_W-1:0]      target;
		logic                            fixed;
		smig_pkg::status_t               st;
		logic                            dir;
		logic [smig_pkg::PRESCALE_W-1:0] ps;
	} move_row_t;

	logic clk;
	logic arst_n;

	smig_cmd_if cmd_ch ();
	smig_res_if res_ch ();

	stepper_move_interval_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// Model state: stored step position per axis, as the block keeps it
	logic signed [smig_pkg::POS_W-1:0] axis_pos [smig_pkg::AXES];

	reload_t     reload_q[$];   // results still owed by the block, oldest first
	reload_t     plan_q[$];     // results of the request just planned
	int unsigned requests_sent;
	int unsigned results_seen;
	int unsigned steps_seen;
	int unsigned nomove_seen;
	int unsigned toolong_seen;
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned burst_left;

	// Directed requests: extremes of duration and position, all three result
	// kinds, zero duration, a distance wider than 32 bits and full 64-step moves.
	// Fixed rows hold their single flag result; the rest go to the predictor.
	move_row_t directed_rows [DIRECTED_MOVES] = '{
		'{2'd0, 32'd100,       32'd0,         1'b1, smig_pkg::ST_NOMOVE,  1'b0, 16'h0000},
		'{2'd0, 32'hFFFF_FFFF, 32'd0,         1'b1, smig_pkg::ST_NOMOVE,  1'b0, 16'hFFFF},
		'{2'd1, 32'd65535,     32'd64,        1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000},
		'{2'd1, 32'd65536,     32'd0,         1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000},
		'{2'd1, 32'd0,         32'd1,         1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000},
		'{2'd2, 32'd1000,      32'd65,        1'b1, smig_pkg::ST_TOOLONG, 1'b0, 16'h0000},
		'{2'd2, 32'd1000,      32'd1,         1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000},
		'{2'd2, 32'h8000_0000, 32'h8000_0000, 1'b1, smig_pkg::ST_TOOLONG, 1'b1, 16'hFFFF},
		'{2'd2, 32'h0001_FFFF, 32'h7FFF_FFFF, 1'b1, smig_pkg::ST_TOOLONG, 1'b0, 16'h0001},
		'{2'd2, 32'd7,         32'h7FFF_FFFC, 1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000},
		'{2'd3, 32'd65535,     32'hFFFF_FFFB, 1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000},
		'{2'd3, 32'd100,       32'hFFFF_FFFB, 1'b1, smig_pkg::ST_NOMOVE,  1'b0, 16'h0000},
		'{2'd3, 32'd1,         32'hFFFF_FFFD, 1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000},
		'{2'd0, 32'd65535,     32'd63,        1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000},
		'{2'd0, 32'd12345678,  32'd30,        1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000},
		'{2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFF6, 1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000},
		'{2'd1, 32'h5555_5555, 32'h8000_0000, 1'b1, smig_pkg::ST_TOOLONG, 1'b1, 16'h7FFF},
		'{2'd0, 32'hAAAA_AAAA, 32'd30,        1'b1, smig_pkg::ST_NOMOVE,  1'b0, 16'hFFFF},
		'{2'd0, 32'd65535,     32'd94,        1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000},
		'{2'd0, 32'd65536,     32'd30,        1'b0, smig_pkg::ST_STEP,    1'b0, 16'h0000}
	};

	// Print one mismatch line and count it
	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		$display("%0t ns: %s: got %h, want %h", $time, what, got, want);
	endtask

	// Bit mask of the ruler levels whose steps take one extra tick, so the
	// division remainder spreads evenly over the move
	function automatic int unsigned remainder_spread(input int unsigned steps,
		input int unsigned rem);
		int unsigned mask, a, b, off, bit_v, q, y, share;
		mask  = 0;
		a     = steps;
		b     = rem + 1;
		off   = 1;
		bit_v = 1;
		q     = 2;
		while (b != 0 && a != 0) begin
			y     = steps - (off - 1);
			share = y / q;
			if (y % q != 0)
				share++;
			if (b > share) begin
				b    -= share;
				mask |= bit_v;
			end
			off   <<= 1;
			a     >>= 1;
			bit_v <<= 1;
			q     <<= 1;
		end
		return mask;
	endfunction

	// Work out the results of one accepted request into plan_q and advance
	// the stored position of its axis to the target
	function automatic void plan_reloads(input logic [smig_pkg::AXIS_IN_W-1:0] ax,
		input logic [smig_pkg::TIME_W-1:0] ticks,
		input logic signed [smig_pkg::POS_W-1:0] target);
		logic [smig_pkg::TIME_W-1:0]     x;
		int unsigned                     halvings, steps, base, mask, i, ruler, slot;
		logic [smig_pkg::PRESCALE_W-1:0] ps;
		longint                          delta;
		logic                            dir;
		reload_t                         r;
		plan_q.delete();
		slot     = ax % smig_pkg::AXES;
		x        = ticks;
		halvings = 0;
		while (x >= 32'd65536) begin
			x = x >> 1;
			halvings++;
		end
		ps    = smig_pkg::PRESCALE_W'((64'd1 << halvings) - 64'd1);
		delta = longint'(target) - longint'(axis_pos[slot]);
		axis_pos[slot] = target;
		if (delta == 0) begin
			plan_q.push_back('{'0, ps, 1'b0, smig_pkg::ST_NOMOVE, 1'b1});
			return;
		end
		dir   = (delta < 0);
		delta = dir ? -delta : delta;
		if (delta > smig_pkg::MAX_STEPS) begin
			plan_q.push_back('{'0, ps, dir, smig_pkg::ST_TOOLONG, 1'b1});
			return;
		end
		steps = int'(delta);
		base  = x / steps;
		mask  = remainder_spread(steps, x % steps);
		for (i = 0; i < steps; i++) begin
			ruler       = ~i & (i + 1);
			r.interval  = smig_pkg::INTERVAL_W'((ruler & mask) != 0 ? base + 1 : base);
			r.prescale  = ps;
			r.direction = dir;
			r.status    = smig_pkg::ST_STEP;
			r.last      = (i + 1 == steps);
			plan_q.push_back(r);
		end
	endfunction

	// Offer one request and hold it until the block takes it; return on the
	// accepting edge with valid still high
	task automatic issue_move(input logic [smig_pkg::AXIS_IN_W-1:0] ax,
		input logic [smig_pkg::TIME_W-1:0] ticks, input logic [smig_pkg::POS_W-1:0] target,
		input logic fixed, input reload_t fixed_result);
		cmd_ch.valid           <= 1'b1;
		cmd_ch.axis            <= ax;
		cmd_ch.move_time       <= ticks;
		cmd_ch.target_position <= target;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		requests_sent++;
		plan_reloads(ax, ticks, target);
		if (fixed)
			reload_q.push_back(fixed_result);
		else
			foreach (plan_q[k])
				reload_q.push_back(plan_q[k]);
	endtask

	// Keep offering within a burst; at its end drop valid for a random gap
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20)
				: $urandom_range(0, 4);
		end
	endtask

	// Drop valid and hold until the block owes nothing
	task automatic drain_sender();
		cmd_ch.valid <= 1'b0;
		while (reload_q.size() != 0)
			@(posedge clk);
	endtask

	// Draw a random request: mostly real moves of 1..64 steps from where the
	// axis stands, the rest no-moves, too-long moves and arbitrary targets
	task automatic pick_random_move(output logic [smig_pkg::AXIS_IN_W-1:0] ax,
		output logic [smig_pkg::TIME_W-1:0] ticks,
		output logic [smig_pkg::POS_W-1:0] target);
		int unsigned                sel, span;
		logic [smig_pkg::POS_W-1:0] here;
		ax    = smig_pkg::AXIS_IN_W'($urandom_range(0, smig_pkg::AXES - 1));
		here  = axis_pos[ax % smig_pkg::AXES];
		ticks = $urandom >> $urandom_range(0, 31);
		sel   = $urandom_range(0, 99);
		if (sel < 5)
			ticks = '0;
		else if (sel >= 95)
			ticks = '1;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			span   = $urandom_range(0, 1) ? $urandom_range(1, 8)
				: $urandom_range(1, smig_pkg::MAX_STEPS);
			target = $urandom_range(0, 1) ? here + span : here - span;
		end else if (sel < 80) begin
			target = here;
		end else if (sel < 90) begin
			span   = $urandom_range(smig_pkg::MAX_STEPS + 1, 5000);
			target = $urandom_range(0, 1) ? here + span : here - span;
		end else begin
			target = $urandom;
		end
	endtask

	// Free-running 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Assert reset once at the start, then release it
	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// End the run if it hangs
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("Mismatches found");
		$finish;
	end

	// Receiver: stall on a pattern chosen by bits 8:7 of a tick count, and once,
	// early in the random phase, hold off long enough for the block to back up
	// and stall the request channel while the sender keeps offering
	initial begin : receiver
		int unsigned tick;
		bit          held;
		tick = 0;
		held = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (arst_n !== 1'b1) begin
				res_ch.ready <= 1'b0;
			end else if (!held && requests_sent >= DIRECTED_MOVES + 8) begin
				held = 1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				case (tick[8:7])
					2'd0: res_ch.ready <= 1'b1;
					2'd1: res_ch.ready <= 1'($urandom_range(0, 1));
					2'd2: res_ch.ready <= ($urandom_range(0, 3) == 0);
					default: res_ch.ready <= tick[0];
				endcase
			end
		end
	end

	// Check every result the block hands over against the oldest expectation
	always @(posedge clk) begin : result_check
		reload_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			results_seen++;
			if (reload_q.size() == 0) begin
				note_mismatch("result with nothing pending", 32'(res_ch.interval), '0);
			end else begin
				want = reload_q.pop_front();
				case (want.status)
					smig_pkg::ST_NOMOVE:  nomove_seen++;
					smig_pkg::ST_TOOLONG: toolong_seen++;
					default:              steps_seen++;
				endcase
				if (res_ch.interval !== want.interval)
					note_mismatch("interval", 32'(res_ch.interval), 32'(want.interval));
				if (res_ch.prescale !== want.prescale)
					note_mismatch("prescale", 32'(res_ch.prescale), 32'(want.prescale));
				if (res_ch.direction !== want.direction)
					note_mismatch("direction", 32'(res_ch.direction), 32'(want.direction));
				if (res_ch.status !== want.status)
					note_mismatch("status", 32'(res_ch.status), 32'(want.status));
				if (res_ch.last !== want.last)
					note_mismatch("last", 32'(res_ch.last), 32'(want.last));
			end
		end
	end

	// Stimulus: directed table, a full drain, then random requests with one
	// more drain halfway through
	initial begin : stimulus
		logic [smig_pkg::AXIS_IN_W-1:0] ax;
		logic [smig_pkg::TIME_W-1:0]    ticks;
		logic [smig_pkg::POS_W-1:0]     target;
		move_row_t                      row;
		int                             n;

		foreach (axis_pos[a])
			axis_pos[a] = '0;
		requests_sent = 0;
		results_seen  = 0;
		steps_seen    = 0;
		nomove_seen   = 0;
		toolong_seen  = 0;
		mismatches    = 0;
		burst_left    = 0;

		cmd_ch.valid           <= 1'b0;
		cmd_ch.axis            <= '0;
		cmd_ch.move_time       <= '0;
		cmd_ch.target_position <= '0;

		// Hold until reset is released
		do
			@(posedge clk);
		while (arst_n !== 1'b1);
		@(posedge clk);

		for (n = 0; n < DIRECTED_MOVES; n++) begin
			row = directed_rows[n];
			issue_move(row.ax, row.ticks, row.target, row.fixed,
				'{'0, row.ps, row.dir, row.st, 1'b1});
			pace_sender();
		end
		drain_sender();

		for (n = 0; n < RANDOM_MOVES; n++) begin
			pick_random_move(ax, ticks, target);
			issue_move(ax, ticks, target, 1'b0, '0);
			if (n == RANDOM_MOVES / 2)
				drain_sender();
			else
				pace_sender();
		end

		// Wait out everything owed, then linger for any stray result
		drain_sender();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (reload_q.size() != 0)
			note_mismatch("results never delivered", '0, 32'(reload_q.size()));

		$display("Covered %0d move requests over %0d axes in %0d cycles", requests_sent,
			smig_pkg::AXES, cycle_count);
		$display("Checked %0d results: %0d step reloads, %0d no-move, %0d too-long",
			results_seen, steps_seen, nomove_seen, toolong_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
design/smig_pkg.sv
design/smig_if.sv
design/smig_dp.sv
design/smig_ctrl.sv
design/stepper_move_interval_generator.sv
sim/testbench.sv
